/* rtl/msp_pkg.sv */
// msp_pkg: constants, field widths, register codes and the microcode store
// for the motor speed pi controller. depends on nothing.
`timescale 1ns / 1ps

package msp_pkg;

   // encoder pulses per revolution, a power of two (16 .. 32768)
   localparam int PULSES_PER_REV = 2048;
   localparam int SPEED_SHIFT    = $clog2(PULSES_PER_REV);
   // 120 rpm per pulse-per-second times 16 for the 1/16 rpm scale
   localparam logic [15:0] SPEED_FACTOR = 16'd1920;

   localparam int PULSE_W = 16;
   localparam int ADC_W   = 10;
   localparam int GAIN_W  = 16;
   localparam int RPM_W   = 16;
   localparam int DUTY_W  = 8;
   localparam int FRAC_W  = 4;
   localparam int SPEED_W = RPM_W + FRAC_W;     // 1/16 rpm
   localparam int ERR_W   = SPEED_W + 1;        // signed difference
   localparam int ESUM_W  = 22;
   localparam int MUL_A_W = GAIN_W + 1;         // unsigned operand, sign bit added
   localparam int MUL_B_W = ESUM_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = PROD_W + 1;
   localparam int ACC_SHIFT = 20;               // q0.16 gain times 1/16 rpm

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_KP_GAIN        = 3'd0,
      CSR_KI_GAIN        = 3'd1,
      CSR_ADC_OFFSET     = 3'd2,
      CSR_REF_SLOPE      = 3'd3,
      CSR_RPM_FLOOR      = 3'd4,
      CSR_INTEGRAL_LIMIT = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      MA_FACTOR = 2'd0,
      MA_SLOPE  = 2'd1,
      MA_KP     = 2'd2,
      MA_KI     = 2'd3
   } mul_a_sel_type;

   typedef enum logic [1:0] {
      MB_PULSES    = 2'd0,
      MB_ADC_DIFF  = 2'd1,
      MB_ERROR     = 2'd2,
      MB_ERROR_SUM = 2'd3
   } mul_b_sel_type;

   localparam int STEP_W = 4;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_IDLE  = 4'd0;
   localparam step_type STEP_SPEED = 4'd1;
   localparam step_type STEP_AVG   = 4'd2;
   localparam step_type STEP_REF   = 4'd3;
   localparam step_type STEP_ERR   = 4'd4;
   localparam step_type STEP_KP    = 4'd5;
   localparam step_type STEP_KI    = 4'd6;
   localparam step_type STEP_INTEG = 4'd7;
   localparam step_type STEP_OUT   = 4'd8;

   typedef struct packed {
      mul_a_sel_type mul_a;
      mul_b_sel_type mul_b;
      logic          mul_en;
      logic          ld_avg;
      logic          ld_ref;
      logic          ld_err;
      logic          acc_ld;
      logic          acc_add;
      logic          ld_esum;
      logic          ld_out;
      logic          wait_req;
      logic          wait_rsp;
      logic          jump;
      step_type      target;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type cw;
      cw = '0;
      unique case (step)
         STEP_IDLE: begin
            cw.wait_req = 1'b1;
         end
         STEP_SPEED: begin
            cw.mul_a  = MA_FACTOR;
            cw.mul_b  = MB_PULSES;
            cw.mul_en = 1'b1;
         end
         STEP_AVG: begin
            cw.ld_avg = 1'b1;
            cw.mul_a  = MA_SLOPE;
            cw.mul_b  = MB_ADC_DIFF;
            cw.mul_en = 1'b1;
         end
         STEP_REF: begin
            cw.ld_ref = 1'b1;
         end
         STEP_ERR: begin
            cw.ld_err = 1'b1;
         end
         STEP_KP: begin
            cw.mul_a  = MA_KP;
            cw.mul_b  = MB_ERROR;
            cw.mul_en = 1'b1;
         end
         STEP_KI: begin
            cw.acc_ld = 1'b1;
            cw.mul_a  = MA_KI;
            cw.mul_b  = MB_ERROR_SUM;
            cw.mul_en = 1'b1;
         end
         STEP_INTEG: begin
            cw.acc_add = 1'b1;
            cw.ld_esum = 1'b1;
         end
         STEP_OUT: begin
            cw.ld_out   = 1'b1;
            cw.wait_rsp = 1'b1;
            cw.jump     = 1'b1;
            cw.target   = STEP_IDLE;
         end
         default: begin
            cw.jump   = 1'b1;
            cw.target = STEP_IDLE;
         end
      endcase
      return cw;
   endfunction

endpackage

/* rtl/msp_ifc.sv */
// msp_ifc: valid/ready channel interfaces for requests, responses and
// register writes. depends on msp_pkg for field widths.
`timescale 1ns / 1ps

interface msp_req_if;
   logic                       valid;
   logic                       ready;
   logic [msp_pkg::PULSE_W-1:0] pulse_count;
   logic [msp_pkg::ADC_W-1:0]   adc_sample;

   modport source (output valid, pulse_count, adc_sample, input ready);
   modport sink   (input valid, pulse_count, adc_sample, output ready);
endinterface

interface msp_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [msp_pkg::DUTY_W-1:0] duty;
   logic [msp_pkg::RPM_W-1:0]  reference_rpm;
   logic [msp_pkg::RPM_W-1:0]  average_rpm;

   modport source (output valid, duty, reference_rpm, average_rpm, input ready);
   modport sink   (input valid, duty, reference_rpm, average_rpm, output ready);
endinterface

interface msp_csr_if;
   logic                           valid;
   logic                           ready;
   logic [msp_pkg::CSR_ADDR_W-1:0] index;
   logic [msp_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/motor_speed_pi_controller.sv */
// motor_speed_pi_controller: pi speed loop with clamped integrator, run by a
// microcode sequencer over one shared multiplier.
// depends on msp_pkg and the channel interfaces in msp_ifc.
//
//   channel    dir   words                                   handshake
//   req_bus    in    pulse_count, adc_sample                 valid/ready
//   rsp_bus    out   duty, reference_rpm, average_rpm        valid/ready
//   csr_bus    in    index, data (register write)            valid/ready, always ready
//
// an accepted word passes through the microcode steps speed, average,
// reference, error, kp, ki, integrate and output to the response register,
// paced by the single 17x22 multiplier that is used four times in sequence.
// the idle step then takes the next word. a new word is taken in the cycle
// after the response register is loaded, while that response waits. a stalled
// response holds the sequencer at its output step. synchronous reset returns
// the step counter to idle, loads register defaults and clears speed and integrator.
`timescale 1ns / 1ps

module motor_speed_pi_controller (
   input  logic      clock,
   input  logic      reset,
   msp_req_if.sink   req_bus,
   msp_rsp_if.source rsp_bus,
   msp_csr_if.sink   csr_bus
);

   // configuration registers
   logic [msp_pkg::GAIN_W-1:0]     kp_gain_ff;
   logic [msp_pkg::GAIN_W-1:0]     ki_gain_ff;
   logic [msp_pkg::ADC_W-1:0]      adc_offset_ff;
   logic [msp_pkg::GAIN_W-1:0]     ref_slope_ff;
   logic [msp_pkg::RPM_W-1:0]      rpm_floor_ff;
   logic [msp_pkg::RPM_W-1:0]      integral_limit_ff;

   // sequencer
   msp_pkg::step_type              step_ff, step_in;
   msp_pkg::ctrl_word_type         cw;
   logic                           req_fire;
   logic                           rsp_free;
   logic                           hold;

   // datapath
   logic [msp_pkg::PULSE_W-1:0]    pulses_ff;
   logic [msp_pkg::ADC_W-1:0]      adc_ff;
   logic [msp_pkg::ADC_W-1:0]      adc_diff;
   logic signed [msp_pkg::MUL_A_W-1:0] mul_a;
   logic signed [msp_pkg::MUL_B_W-1:0] mul_b;
   logic signed [msp_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [msp_pkg::PROD_W-1:0]     speed_wide;
   logic [msp_pkg::SPEED_W-1:0]    speed;
   logic [msp_pkg::SPEED_W:0]      avg_sum;
   logic [msp_pkg::SPEED_W-1:0]    prev_speed_ff;
   logic [msp_pkg::SPEED_W-1:0]    avg_ff;
   logic [msp_pkg::PROD_W-1:0]     ref_wide;
   logic [msp_pkg::SPEED_W-1:0]    ref_ff, ref_in;
   logic signed [msp_pkg::ERR_W-1:0]   err_ff, err_in;
   logic signed [msp_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic signed [msp_pkg::ESUM_W-1:0]  esum_ff, esum_in;
   logic signed [msp_pkg::ESUM_W:0]    esum_raw;
   logic signed [msp_pkg::ESUM_W:0]    lim_pos;
   logic signed [msp_pkg::ESUM_W:0]    lim_neg;
   logic [msp_pkg::DUTY_W-1:0]     duty_in;

   // response register
   logic                           rsp_valid_ff;
   logic [msp_pkg::DUTY_W-1:0]     duty_ff;
   logic [msp_pkg::RPM_W-1:0]      reference_rpm_ff;
   logic [msp_pkg::RPM_W-1:0]      average_rpm_ff;

   assign cw       = msp_pkg::ucode_rom(step_ff);
   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign hold     = (cw.wait_req && !req_fire) || (cw.wait_rsp && !rsp_free);

   assign req_bus.ready = cw.wait_req;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.duty          = duty_ff;
   assign rsp_bus.reference_rpm = reference_rpm_ff;
   assign rsp_bus.average_rpm   = average_rpm_ff;

   always_comb begin
      if (hold) begin
         step_in = step_ff;
      end else if (cw.jump) begin
         step_in = cw.target;
      end else begin
         step_in = step_ff + msp_pkg::STEP_W'(1);
      end
   end

   // shared multiplier operands
   assign adc_diff = (adc_ff > adc_offset_ff) ? (adc_ff - adc_offset_ff) : '0;

   always_comb begin
      case (cw.mul_a)
         msp_pkg::MA_FACTOR: mul_a = $signed({1'b0, msp_pkg::SPEED_FACTOR});
         msp_pkg::MA_SLOPE:  mul_a = $signed({1'b0, ref_slope_ff});
         msp_pkg::MA_KP:     mul_a = $signed({1'b0, kp_gain_ff});
         default:            mul_a = $signed({1'b0, ki_gain_ff});
      endcase
      case (cw.mul_b)
         msp_pkg::MB_PULSES:
            mul_b = $signed({{(msp_pkg::MUL_B_W-msp_pkg::PULSE_W){1'b0}}, pulses_ff});
         msp_pkg::MB_ADC_DIFF:
            mul_b = $signed({{(msp_pkg::MUL_B_W-msp_pkg::ADC_W){1'b0}}, adc_diff});
         msp_pkg::MB_ERROR:
            mul_b = {{(msp_pkg::MUL_B_W-msp_pkg::ERR_W){err_ff[msp_pkg::ERR_W-1]}}, err_ff};
         default:
            mul_b = esum_ff;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // measured speed and two-period average
   assign speed_wide = $unsigned(prod_ff) >> msp_pkg::SPEED_SHIFT;
   assign speed = (|speed_wide[msp_pkg::PROD_W-1:msp_pkg::SPEED_W]) ?
                  '1 : speed_wide[msp_pkg::SPEED_W-1:0];
   assign avg_sum = {1'b0, speed} + {1'b0, prev_speed_ff};

   // reference: floor plus slope term, saturated to the speed range
   assign ref_wide = {{(msp_pkg::PROD_W-msp_pkg::SPEED_W){1'b0}}, rpm_floor_ff,
                      {msp_pkg::FRAC_W{1'b0}}}
                   + ($unsigned(prod_ff) >> msp_pkg::FRAC_W);
   assign ref_in = (|ref_wide[msp_pkg::PROD_W-1:msp_pkg::SPEED_W]) ?
                   '1 : ref_wide[msp_pkg::SPEED_W-1:0];

   assign err_in = $signed({1'b0, ref_ff}) - $signed({1'b0, avg_ff});

   always_comb begin
      acc_in = acc_ff;
      if (cw.acc_ld) begin
         acc_in = msp_pkg::ACC_W'(prod_ff);
      end else if (cw.acc_add) begin
         acc_in = acc_ff + msp_pkg::ACC_W'(prod_ff);
      end
   end

   // integrator with symmetric clamp
   assign esum_raw = $signed({esum_ff[msp_pkg::ESUM_W-1], esum_ff})
                   + (msp_pkg::ESUM_W+1)'(err_ff);
   assign lim_pos  = $signed({{(msp_pkg::ESUM_W+1-msp_pkg::SPEED_W){1'b0}},
                              integral_limit_ff, {msp_pkg::FRAC_W{1'b0}}});
   assign lim_neg  = -lim_pos;

   always_comb begin
      if (esum_raw > lim_pos) begin
         esum_in = lim_pos[msp_pkg::ESUM_W-1:0];
      end else if (esum_raw < lim_neg) begin
         esum_in = lim_neg[msp_pkg::ESUM_W-1:0];
      end else begin
         esum_in = esum_raw[msp_pkg::ESUM_W-1:0];
      end
   end

   // duty: negative gives zero, otherwise floor saturated at full scale
   always_comb begin
      if (acc_ff[msp_pkg::ACC_W-1]) begin
         duty_in = '0;
      end else if (|acc_ff[msp_pkg::ACC_W-2:msp_pkg::ACC_SHIFT+msp_pkg::DUTY_W]) begin
         duty_in = '1;
      end else begin
         duty_in = acc_ff[msp_pkg::ACC_SHIFT+msp_pkg::DUTY_W-1:msp_pkg::ACC_SHIFT];
      end
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff           <= msp_pkg::STEP_IDLE;
         rsp_valid_ff      <= 1'b0;
         prev_speed_ff     <= '0;
         esum_ff           <= '0;
         kp_gain_ff        <= 16'd4588;
         ki_gain_ff        <= 16'd2458;
         adc_offset_ff     <= 10'd600;
         ref_slope_ff      <= 16'd1210;
         rpm_floor_ff      <= 16'd1000;
         integral_limit_ff <= 16'd5000;
      end else begin
         step_ff <= step_in;
         if (cw.ld_out && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cw.ld_avg) begin
            prev_speed_ff <= speed;
         end
         if (cw.ld_esum) begin
            esum_ff <= esum_in;
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               msp_pkg::CSR_KP_GAIN:        kp_gain_ff        <= csr_bus.data;
               msp_pkg::CSR_KI_GAIN:        ki_gain_ff        <= csr_bus.data;
               msp_pkg::CSR_ADC_OFFSET:     adc_offset_ff     <= csr_bus.data[msp_pkg::ADC_W-1:0];
               msp_pkg::CSR_REF_SLOPE:      ref_slope_ff      <= csr_bus.data;
               msp_pkg::CSR_RPM_FLOOR:      rpm_floor_ff      <= csr_bus.data;
               msp_pkg::CSR_INTEGRAL_LIMIT: integral_limit_ff <= csr_bus.data;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pulses_ff <= req_bus.pulse_count;
         adc_ff    <= req_bus.adc_sample;
      end
      if (cw.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cw.ld_avg) begin
         avg_ff <= avg_sum[msp_pkg::SPEED_W:1];
      end
      if (cw.ld_ref) begin
         ref_ff <= ref_in;
      end
      if (cw.ld_err) begin
         err_ff <= err_in;
      end
      acc_ff <= acc_in;
      if (cw.ld_out && rsp_free) begin
         duty_ff          <= duty_in;
         reference_rpm_ff <= ref_ff[msp_pkg::SPEED_W-1:msp_pkg::FRAC_W];
         average_rpm_ff   <= avg_ff[msp_pkg::SPEED_W-1:msp_pkg::FRAC_W];
      end
   end

   // an accepted word starts the program at its first step
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> step_ff == msp_pkg::STEP_SPEED)
      else $error("sequencer did not start after request");

   // a pending response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (step_ff == msp_pkg::STEP_OUT && rsp_valid_ff && !rsp_bus.ready)
      |=> step_ff == msp_pkg::STEP_OUT && $stable(duty_ff))
      else $error("response register overwritten while stalled");

   // integrator stays inside its limit after an update
   a_esum_clamp: assert property (@(posedge clock) disable iff (reset)
      step_ff == msp_pkg::STEP_INTEG |=>
      (esum_ff <= lim_pos) && (esum_ff >= lim_neg))
      else $error("integrator outside its clamp");

   // a response appears only from the output step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step_ff) == msp_pkg::STEP_OUT)
      else $error("response raised outside the output step");

endmodule
